// ===== rtl/core/tmis_pkg.sv =====
// Package for the tape machine step: payload types, status codes and opcode fields.
package tmis_pkg;

  localparam int unsigned TAPE_DEPTH_DEF = 65536;
  localparam int unsigned PTR_SPAN       = 65536;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HALT  = 2'd1,
    ST_FAULT = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] instruction;
    logic [7:0]  in_byte;
    logic        in_short;
  } tmis_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] next_pointer;
    logic [7:0]  out_byte;
    logic [8:0]  print_count;
    logic [8:0]  read_count;
  } tmis_out_t;

  // instruction classes
  localparam logic [15:0] OP_ADD_MASK   = 16'hfc00;
  localparam logic [15:0] OP_ADD        = 16'h1000;
  localparam logic [15:0] OP_JABS_BIT   = 16'h8000;
  localparam logic [15:0] OP_JABS_MASK  = 16'h7fff;
  localparam logic [15:0] OP_SYS_MASK   = 16'hf000;
  localparam logic [15:0] OP_SYS        = 16'h2000;
  localparam logic [15:0] OP_BR_MASK    = 16'he000;
  localparam logic [15:0] OP_BRZ        = 16'h4000;
  localparam logic [15:0] OP_BRNZ       = 16'h6000;
  localparam logic [15:0] OP_BR_TARGET  = 16'h1fff;

  // add destinations, bits 9:8
  localparam logic [1:0] DST_IP   = 2'b00;
  localparam logic [1:0] DST_DP   = 2'b01;
  localparam logic [1:0] DST_CELL = 2'b11;

  // system targets, bits 11:8
  localparam logic [3:0] SYS_HALT  = 4'd0;
  localparam logic [3:0] SYS_PRINT = 4'd1;
  localparam logic [3:0] SYS_LOAD  = 4'd2;

  localparam logic [8:0] OPERAND_BIAS = 9'd127;

endpackage

// ===== rtl/core/tmis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tmis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tape_machine_instruction_step.sv =====
// Top level of the tape machine step: pointers, tape memory and one-instruction executor.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_ready    tmis_in_t  (instruction, in_byte, in_short)
// out_     out  out_valid / out_ready  tmis_out_t (status, next_pointer, out_byte, counts)
// cfg_     in   cfg_valid / cfg_ready  cfg_data (program length)
//
// The accept cycle issues the tape read at the current cell; once the output register is
// free, the executor works on the registered read data and writes the cell back.
// After reset a clearing pass zeroes the tape, during which in_ready stays low;
// configuration transactions are taken throughout.
// A result waits in the output register; the next transaction is accepted meanwhile,
// and execution holds (read data held) until the output register frees up.
module tape_machine_instruction_step import tmis_pkg::*; #(
  parameter int unsigned TAPE_DEPTH = TAPE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tmis_in_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output tmis_out_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = $clog2(TAPE_DEPTH);
  // signed width for cell address arithmetic, holds -DEPTH .. 2*DEPTH-1
  localparam int unsigned SW = AW + 2;
  localparam logic signed [SW-1:0] DEPTH_S = SW'(TAPE_DEPTH);
  // what a 16-bit pointer wrap shifts the cell index by
  localparam logic signed [SW-1:0] WRAP_S  = SW'(PTR_SPAN % TAPE_DEPTH);
  localparam logic [AW-1:0]        LAST_A  = AW'(TAPE_DEPTH - 1);

  // architectural state
  logic [15:0]   prog_len_r;
  logic [15:0]   ip_r,   ip_nxt;
  logic [15:0]   dp_r,   dp_nxt;
  logic [AW-1:0] addr_r, addr_nxt;   // dp_r modulo TAPE_DEPTH

  // clearing pass
  logic          clr_r;
  logic [AW-1:0] clr_idx_r;

  // execute slot and output register
  logic      ex_valid_r;
  tmis_in_t  ex_item_r;
  logic      out_valid_r;
  tmis_out_t out_item_r;

  logic in_fire, ex_fire;

  // tape memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    cell_rd;

  // executor outputs
  tmis_out_t res;
  logic      cell_we;
  logic [7:0] cell_wd;
  logic      dp_we;

  assign cfg_ready = 1'b1;
  assign in_ready  = !ex_valid_r && !clr_r;
  assign in_fire   = in_valid && in_ready;
  assign ex_fire   = ex_valid_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign mem_we    = clr_r || (ex_fire && cell_we);
  assign mem_waddr = clr_r ? clr_idx_r : addr_r;
  assign mem_wdata = clr_r ? 8'd0 : cell_wd;

  tmis_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (addr_r),
    .rdata (cell_rd)
  );

  // ---------------------------------------------------------------------------
  // Executor: one instruction on the current cell
  // ---------------------------------------------------------------------------
  logic [15:0]              op;
  logic signed [8:0]        operand;
  logic [8:0]               count;
  logic [1:0]               dst;
  logic [3:0]               sys_tgt;
  logic                     advance;
  logic signed [17:0]       dp_ext;
  logic                     dp_over, dp_under;
  logic signed [SW-1:0]     t1, t1f, t2, t2f;

  always_comb begin
    op       = ex_item_r.instruction;
    operand  = $signed({1'b0, op[7:0]}) - $signed(OPERAND_BIAS);
    count    = {1'b0, op[7:0]} + 9'd1;
    dst      = op[9:8];
    sys_tgt  = op[11:8];

    // data pointer step and its cell index, kept modulo TAPE_DEPTH
    dp_ext   = $signed({2'b00, dp_r}) + $signed({{9{operand[8]}}, operand});
    dp_over  = !dp_ext[17] && dp_ext[16];
    dp_under = dp_ext[17];
    t1 = $signed({2'b00, addr_r}) + $signed({{(SW-9){operand[8]}}, operand});
    if (t1 < 0) begin
      t1f = t1 + DEPTH_S;
    end else if (t1 >= DEPTH_S) begin
      t1f = t1 - DEPTH_S;
    end else begin
      t1f = t1;
    end
    if (dp_over) begin
      t2 = t1f - WRAP_S;
    end else if (dp_under) begin
      t2 = t1f + WRAP_S;
    end else begin
      t2 = t1f;
    end
    if (t2 < 0) begin
      t2f = t2 + DEPTH_S;
    end else if (t2 >= DEPTH_S) begin
      t2f = t2 - DEPTH_S;
    end else begin
      t2f = t2;
    end

    res        = '0;
    res.status = ST_OK;
    ip_nxt     = ip_r;
    advance    = 1'b0;
    cell_we    = 1'b0;
    cell_wd    = cell_rd + op[7:0] + 8'd129;   // cell + (a - 127) mod 256
    dp_we      = 1'b0;

    if (ip_r == prog_len_r) begin
      res.status = ST_HALT;
    end else if (ip_r > prog_len_r) begin
      res.status = ST_FAULT;
    end else if (op == 16'd0) begin
      advance = 1'b1;
    end else if ((op & OP_ADD_MASK) == OP_ADD) begin
      case (dst)
        DST_IP: begin
          ip_nxt = ip_r + {{7{operand[8]}}, operand};
        end
        DST_DP: begin
          dp_we   = 1'b1;
          advance = 1'b1;
        end
        DST_CELL: begin
          cell_we = 1'b1;
          advance = 1'b1;
        end
        default: begin
          res.status = ST_FAULT;
        end
      endcase
    end else if ((op & OP_JABS_BIT) != 16'd0) begin
      ip_nxt = op & OP_JABS_MASK;
    end else if ((op & OP_SYS_MASK) == OP_SYS) begin
      case (sys_tgt)
        SYS_HALT: begin
          res.status = ST_HALT;
        end
        SYS_PRINT: begin
          res.out_byte    = cell_rd;
          res.print_count = count;
          advance         = 1'b1;
        end
        SYS_LOAD: begin
          if (ex_item_r.in_short) begin
            res.status = ST_FAULT;
          end else begin
            cell_we        = 1'b1;
            cell_wd        = ex_item_r.in_byte;
            res.read_count = count;
            advance        = 1'b1;
          end
        end
        default: begin
          res.status = ST_FAULT;
        end
      endcase
    end else if ((op & OP_BR_MASK) == OP_BRZ) begin
      if (cell_rd == 8'd0) begin
        ip_nxt = op & OP_BR_TARGET;
      end else begin
        advance = 1'b1;
      end
    end else if ((op & OP_BR_MASK) == OP_BRNZ) begin
      if (cell_rd != 8'd0) begin
        ip_nxt = op & OP_BR_TARGET;
      end else begin
        advance = 1'b1;
      end
    end else begin
      res.status = ST_FAULT;
    end

    if (advance) begin
      ip_nxt = ip_r + 16'd1;
    end
    res.next_pointer = ip_nxt;

    dp_nxt   = dp_we ? dp_ext[15:0] : dp_r;
    addr_nxt = dp_we ? t2f[AW-1:0]  : addr_r;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r  <= '0;
      ip_r        <= '0;
      dp_r        <= '0;
      addr_r      <= '0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prog_len_r <= cfg_data;
      end

      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_A) begin
          clr_r <= 1'b0;
        end
      end

      if (in_fire) begin
        ex_valid_r <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end

      if (ex_fire) begin
        ip_r        <= ip_nxt;
        dp_r        <= dp_nxt;
        addr_r      <= addr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_item_r <= in_item;
    end
    if (ex_fire) begin
      out_item_r <= res;
    end
  end

endmodule
